FILE: hw/rtl/min_tracking_stack_defines.svh
// Assertion macros for the min tracking stack checker
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MTS_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mts_pkg.sv
// Types and constants shared by the min tracking stack modules
package mts_pkg;
	localparam int DEPTH   = 1024;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 11;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 112;

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_QUERY = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic exec;      // word accepted this cycle
		logic refill;    // reload top/min from RAM read data
		logic load_out;  // capture result word
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_le1;
	} sts_t;
endpackage

FILE: hw/rtl/mts_ctrl.sv
// Controller: input/output handshake and pop refill sequencing
module mts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_tvalid,
	input  logic [1:0]      action,
	input  logic            out_tready,
	input  mts_pkg::sts_t   sts,
	output logic            in_tready,
	output logic            out_tvalid,
	output mts_pkg::cmd_t   cmd
);
	localparam logic S_IDLE  = 1'b0;
	localparam logic S_POPRD = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic accept;
	logic slow_pop;

	assign in_tready = (state_q == S_IDLE) && (!out_valid_q || out_tready);
	assign accept    = in_tvalid && in_tready;
	assign slow_pop  = accept && (action == mts_pkg::ACT_POP) && !sts.cnt_le1;

	assign cmd.exec     = accept;
	assign cmd.refill   = (state_q == S_POPRD);
	assign cmd.load_out = (accept && !slow_pop) || (state_q == S_POPRD);
	assign out_tvalid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (slow_pop)
					state_d = S_POPRD;
			end
			S_POPRD: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_tready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

FILE: hw/rtl/mts_dp.sv
// Datapath: stack RAM, count, cached top/min and result register
module mts_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mts_pkg::cmd_t                       cmd,
	input  logic [1:0]                          action,
	input  logic signed [mts_pkg::DATA_W-1:0]   push_value,
	output mts_pkg::sts_t                       sts,
	output logic [mts_pkg::OUT_W-1:0]           result
);
	localparam int RAM_W = 2 * mts_pkg::DATA_W;

	logic [RAM_W-1:0]                  mem [mts_pkg::DEPTH];
	logic [RAM_W-1:0]                  rd_q;
	logic [mts_pkg::CNT_W-1:0]         cnt_q;
	logic [mts_pkg::CNT_W-1:0]         cnt_n;
	logic [mts_pkg::CNT_W-1:0]         rd_cnt;
	logic signed [mts_pkg::DATA_W-1:0] top_q;
	logic signed [mts_pkg::DATA_W-1:0] min_q;
	logic signed [mts_pkg::DATA_W-1:0] popped_q;
	logic signed [mts_pkg::DATA_W-1:0] top_n;
	logic signed [mts_pkg::DATA_W-1:0] min_n;
	logic signed [mts_pkg::DATA_W-1:0] pop_v;
	logic signed [mts_pkg::DATA_W-1:0] push_min;
	logic signed [mts_pkg::DATA_W-1:0] res_top;
	logic signed [mts_pkg::DATA_W-1:0] res_min;
	logic [1:0]                        st;
	logic                              wr_en;
	logic                              empty_n;
	logic [mts_pkg::OUT_W-1:0]         result_q;

	assign sts.cnt_le1 = (cnt_q <= mts_pkg::CNT_W'(1));
	assign rd_cnt      = cnt_q - mts_pkg::CNT_W'(2);

	assign push_min = (cnt_q == '0) ? push_value
	                : ((push_value < min_q) ? push_value : min_q);

	always_comb begin
		cnt_n = cnt_q;
		top_n = top_q;
		min_n = min_q;
		pop_v = '0;
		st    = mts_pkg::ST_OK;
		wr_en = 1'b0;
		if (cmd.refill) begin
			top_n = $signed(rd_q[mts_pkg::DATA_W-1:0]);
			min_n = $signed(rd_q[RAM_W-1:mts_pkg::DATA_W]);
			pop_v = popped_q;
		end else if (cmd.exec) begin
			case (action)
				mts_pkg::ACT_PUSH: begin
					if (cnt_q == mts_pkg::CNT_W'(mts_pkg::DEPTH)) begin
						st = mts_pkg::ST_FULL;
					end else begin
						wr_en = 1'b1;
						top_n = push_value;
						min_n = push_min;
						cnt_n = cnt_q + mts_pkg::CNT_W'(1);
					end
				end
				mts_pkg::ACT_POP: begin
					if (cnt_q == '0) begin
						st = mts_pkg::ST_EMPTY;
					end else begin
						pop_v = top_q;
						cnt_n = cnt_q - mts_pkg::CNT_W'(1);
					end
				end
				mts_pkg::ACT_CLEAR: begin
					cnt_n = '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign empty_n = (cnt_n == '0);
	assign res_top = empty_n ? '0 : top_n;
	assign res_min = empty_n ? '0 : min_n;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[cnt_q[mts_pkg::ADDR_W-1:0]] <= {push_min, push_value};
		rd_q <= mem[rd_cnt[mts_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= cnt_n;
	end

	always_ff @(posedge clk) begin
		top_q <= top_n;
		min_q <= min_n;
		if (cmd.exec)
			popped_q <= pop_v;
		if (cmd.load_out)
			result_q <= {2'b00, empty_n, mts_pkg::COUNT_W'(cnt_n),
			             res_min, res_top, pop_v, st};
	end

	assign result = result_q;
endmodule

FILE: hw/rtl/min_tracking_stack.sv
// Top level of the min tracking stack
//
//   channel   dir  handshake                      tdata
//   s_axis    in   s_axis_tvalid/s_axis_tready    action, push_value
//   m_axis    out  m_axis_tvalid/m_axis_tready    status .. is_empty
//
// Push, clear, query and a pop that empties the stack load the result
// register in the cycle they are taken. A pop leaving one or more elements
// goes via S_POPRD, as its new top and minimum come from registered RAM data.
// Reset clears the count; RAM contents need no clearing.
// A finished result waits in the output register; the next word is taken
// in the same cycle the result is taken.
module min_tracking_stack (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// [1:0] action, [33:2] push_value, [39:34] zero
	input  logic [mts_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [1:0] status, [33:2] popped_value, [65:34] top_value,
	// [97:66] min_value, [108:98] element_count, [109] is_empty, [111:110] zero
	output logic [mts_pkg::OUT_W-1:0]   m_axis_tdata
);
	mts_pkg::cmd_t cmd;
	mts_pkg::sts_t sts;
	logic [1:0]    action;
	logic signed [mts_pkg::DATA_W-1:0] push_value;

	assign action     = s_axis_tdata[1:0];
	assign push_value = $signed(s_axis_tdata[mts_pkg::DATA_W+1:2]);

	mts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (s_axis_tvalid),
		.action     (action),
		.out_tready (m_axis_tready),
		.sts        (sts),
		.in_tready  (s_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.cmd        (cmd)
	);

	mts_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (action),
		.push_value (push_value),
		.sts        (sts),
		.result     (m_axis_tdata)
	);
endmodule

FILE: hw/rtl/mts_checker.sv
// Port-level checker for the min tracking stack, bound to the top level
`include "min_tracking_stack_defines.svh"

module mts_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [mts_pkg::OUT_W-1:0] m_axis_tdata
);
	logic                            out_wait;
	logic [mts_pkg::COUNT_W-1:0]     res_cnt;
	logic                            res_empty;
	logic [2*mts_pkg::DATA_W-1:0]    res_top_min;

	assign out_wait    = m_axis_tvalid && !m_axis_tready;
	assign res_cnt     = m_axis_tdata[108:98];
	assign res_empty   = m_axis_tdata[109];
	assign res_top_min = m_axis_tdata[97:34];

	`MTS_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
	`MTS_ASSERT(a_empty_flag, m_axis_tvalid, res_empty == (res_cnt == '0), "is_empty disagrees with count")
	`MTS_ASSERT(a_empty_zero, m_axis_tvalid && res_empty, res_top_min == '0, "top or min nonzero when empty")
	`MTS_ASSERT(a_count_max, m_axis_tvalid, res_cnt <= mts_pkg::COUNT_W'(mts_pkg::DEPTH), "count above depth")
	`MTS_ASSERT(a_no_overrun, s_axis_tready, !out_wait, "input taken while result waits")
endmodule

bind min_tracking_stack mts_checker u_mts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

FILE: sim/mts_checker.sv
// Checker for the min tracking stack: predicts each result word and compares it
`timescale 1ns / 100ps

module mts_scoreboard (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [mts_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	input  logic [mts_pkg::OUT_W-1:0] m_axis_tdata,
	output int                        errors,
	output int                        pending
);
	typedef struct packed {
		logic [1:0]                  status;
		logic [mts_pkg::DATA_W-1:0]  popped;
		logic [mts_pkg::DATA_W-1:0]  top;
		logic [mts_pkg::DATA_W-1:0]  minv;
		logic [mts_pkg::COUNT_W-1:0] count;
		logic                        empty;
	} stack_result_t;

	logic [mts_pkg::DATA_W-1:0] value_mem [mts_pkg::DEPTH];
	logic [mts_pkg::DATA_W-1:0] floor_mem [mts_pkg::DEPTH];
	int                         depth_cnt;
	stack_result_t              due_results [$];

	function automatic stack_result_t stack_step(input logic [1:0] act,
		input logic [mts_pkg::DATA_W-1:0] val);
		stack_result_t r;
		r = '0;
		r.status = mts_pkg::ST_OK;
		case (act)
			mts_pkg::ACT_PUSH: begin
				if (depth_cnt >= mts_pkg::DEPTH) begin
					r.status = mts_pkg::ST_FULL;
				end else begin
					value_mem[depth_cnt] = val;
					if (depth_cnt == 0)
						floor_mem[depth_cnt] = val;
					else if ($signed(val) < $signed(floor_mem[depth_cnt-1]))
						floor_mem[depth_cnt] = val;
					else
						floor_mem[depth_cnt] = floor_mem[depth_cnt-1];
					depth_cnt++;
				end
			end
			mts_pkg::ACT_POP: begin
				if (depth_cnt == 0) begin
					r.status = mts_pkg::ST_EMPTY;
				end else begin
					r.popped = value_mem[depth_cnt-1];
					depth_cnt--;
				end
			end
			mts_pkg::ACT_CLEAR: depth_cnt = 0;
			default: ;
		endcase
		if (depth_cnt != 0) begin
			r.top  = value_mem[depth_cnt-1];
			r.minv = floor_mem[depth_cnt-1];
		end
		r.count = depth_cnt[mts_pkg::COUNT_W-1:0];
		r.empty = (depth_cnt == 0);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [mts_pkg::DATA_W-1:0] exp_v,
		input logic [mts_pkg::DATA_W-1:0] got_v, inout bit bad);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected 0x%h got 0x%h", $time, name, exp_v, got_v);
			bad = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stack_result_t exp_r;
		stack_result_t got_r;
		bit            bad;
		if (!arst_n) begin
			depth_cnt = 0;
			due_results.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			bad = 1'b0;
			if (m_axis_tvalid && m_axis_tready) begin
				got_r.status = m_axis_tdata[1:0];
				got_r.popped = m_axis_tdata[33:2];
				got_r.top    = m_axis_tdata[65:34];
				got_r.minv   = m_axis_tdata[97:66];
				got_r.count  = m_axis_tdata[108:98];
				got_r.empty  = m_axis_tdata[109];
				if (due_results.size() == 0) begin
					$display("%0t: result word with none expected, expected none got 0x%h",
						$time, m_axis_tdata);
					bad = 1'b1;
				end else begin
					exp_r = due_results.pop_front();
					check_field("status", mts_pkg::DATA_W'(exp_r.status),
						mts_pkg::DATA_W'(got_r.status), bad);
					check_field("popped_value", exp_r.popped, got_r.popped, bad);
					check_field("top_value", exp_r.top, got_r.top, bad);
					check_field("min_value", exp_r.minv, got_r.minv, bad);
					check_field("element_count", mts_pkg::DATA_W'(exp_r.count),
						mts_pkg::DATA_W'(got_r.count), bad);
					check_field("is_empty", mts_pkg::DATA_W'(exp_r.empty),
						mts_pkg::DATA_W'(got_r.empty), bad);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				due_results.push_back(stack_step(s_axis_tdata[1:0], s_axis_tdata[33:2]));
			if (bad)
				errors <= errors + 1;
			pending <= due_results.size();
		end
	end
endmodule

FILE: sim/tb_min_tracking_stack.sv
// Testbench top for the min tracking stack: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_min_tracking_stack;
	localparam int LIMIT_CYCLES   = 400000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RAND_PER_PHASE = 140;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [mts_pkg::IN_W-1:0]  s_axis_tdata = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [mts_pkg::OUT_W-1:0] m_axis_tdata;

	int               errors;
	int               pending;
	int               cycles = 0;
	int unsigned      send_idle_pct = 0;
	int unsigned      stall_pct = 0;
	bit               hold_req = 1'b0;

	always #5 clk = ~clk;

	min_tracking_stack i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	mts_scoreboard i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.pending       (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					m_axis_tready <= 1'b0;
					@(posedge clk);
				end
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
				@(posedge clk);
			end
		end
	end

	function automatic logic [mts_pkg::DATA_W-1:0] rand_value();
		case ($urandom_range(9))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2, 3, 4: return $urandom_range(15) - 8;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(input logic [1:0] act, input logic [mts_pkg::DATA_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, val, act};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic random_phase();
		int n;
		int len;
		int unsigned r;
		n = 0;
		while (n < RAND_PER_PHASE) begin
			r = $urandom_range(99);
			if (r < 15) begin
				len = $urandom_range(5, 40);
				repeat (len) send_word(mts_pkg::ACT_PUSH, rand_value());
				n += len;
			end else if (r < 25) begin
				len = $urandom_range(5, 40);
				repeat (len) send_word(mts_pkg::ACT_POP, $urandom());
				n += len;
			end else begin
				r = $urandom_range(99);
				if (r < 40)
					send_word(mts_pkg::ACT_PUSH, rand_value());
				else if (r < 75)
					send_word(mts_pkg::ACT_POP, $urandom());
				else if (r < 80)
					send_word(mts_pkg::ACT_CLEAR, $urandom());
				else
					send_word(mts_pkg::ACT_QUERY, $urandom());
				n++;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty errors, extremes, equal minimums, clear with data
		send_word(mts_pkg::ACT_POP, $urandom());
		send_word(mts_pkg::ACT_QUERY, $urandom());
		send_word(mts_pkg::ACT_CLEAR, $urandom());
		send_word(mts_pkg::ACT_PUSH, 32'h7FFF_FFFF);
		send_word(mts_pkg::ACT_PUSH, 32'h7FFF_FFFF);
		send_word(mts_pkg::ACT_PUSH, 32'h8000_0000);
		send_word(mts_pkg::ACT_PUSH, 32'h0000_0000);
		send_word(mts_pkg::ACT_PUSH, 32'hFFFF_FFFF);
		send_word(mts_pkg::ACT_PUSH, 32'h8000_0000);
		send_word(mts_pkg::ACT_QUERY, 32'hFFFF_FFFF);
		repeat (6) send_word(mts_pkg::ACT_POP, $urandom());
		send_word(mts_pkg::ACT_POP, 32'hFFFF_FFFF);
		send_word(mts_pkg::ACT_PUSH, 32'h0000_3039);
		send_word(mts_pkg::ACT_PUSH, 32'h5555_5555);
		send_word(mts_pkg::ACT_CLEAR, 32'hFFFF_FFFF);
		send_word(mts_pkg::ACT_QUERY, $urandom());
		send_word(mts_pkg::ACT_PUSH, 32'hAAAA_AAAA);
		send_word(mts_pkg::ACT_POP, $urandom());
		drain();

		// fill to the top, push past it, then clear a full stack
		send_idle_pct = 8;
		stall_pct = 8;
		repeat (mts_pkg::DEPTH + 3) send_word(mts_pkg::ACT_PUSH, rand_value());
		send_word(mts_pkg::ACT_POP, $urandom());
		send_word(mts_pkg::ACT_PUSH, rand_value());
		send_word(mts_pkg::ACT_PUSH, rand_value());
		send_word(mts_pkg::ACT_QUERY, $urandom());
		send_word(mts_pkg::ACT_CLEAR, $urandom());
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					hold_req = 1'b1;
				end
				1: begin
					send_idle_pct = 75;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 75;
				end
				default: begin
					send_idle_pct = 8;
					stall_pct = 8;
				end
			endcase
			random_phase();
			drain();
		end

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mts_pkg.sv
hw/rtl/mts_ctrl.sv
hw/rtl/mts_dp.sv
hw/rtl/min_tracking_stack.sv
hw/rtl/mts_checker.sv
sim/mts_checker.sv
sim/tb_min_tracking_stack.sv
